FILE: rtl/tun_pkg.sv
// Shared types, widths and the datapath step function for the triangle unit normal block.
`timescale 1ns / 1ps
package tun_pkg;

  localparam int CW      = 24;   // vertex coordinate, Q12.12
  localparam int EW      = 25;   // edge component
  localparam int PW      = 50;   // edge product
  localparam int NW      = 51;   // cross product component
  localparam int MW      = 24;   // prescaled magnitude
  localparam int KW      = 5;    // prescale shift amount
  localparam int SQW     = 64;   // isqrt working width
  localparam int LW      = 32;   // root width
  localparam int SQ_STG  = 16;   // isqrt stages, two iterations each
  localparam int NUMW    = 48;   // divider numerator / remainder width
  localparam int DENW    = 33;   // divider denominator width
  localparam int QW      = 15;   // quotient bits
  localparam int DV_STG  = 8;    // divider stages, two quotient bits each, one in the last
  localparam int OW      = 16;   // output component, Q1.14
  localparam int NORM_ONE = 16384;
  // valid chain: 9 front stages, isqrt, num/den stage, divider
  localparam int LAT     = 9 + SQ_STG + 1 + DV_STG;

  typedef struct packed {
    logic signed [CW-1:0] apex_x;
    logic signed [CW-1:0] apex_y;
    logic signed [CW-1:0] apex_z;
    logic signed [CW-1:0] first_x;
    logic signed [CW-1:0] first_y;
    logic signed [CW-1:0] first_z;
    logic signed [CW-1:0] second_x;
    logic signed [CW-1:0] second_y;
    logic signed [CW-1:0] second_z;
  } in_t;

  typedef struct packed {
    logic signed [OW-1:0] normal_x;
    logic signed [OW-1:0] normal_y;
    logic signed [OW-1:0] normal_z;
    logic                 degenerate;
  } out_t;

  typedef struct packed {
    logic [SQW-1:0] x;
    logic [SQW-1:0] res;
  } sq_t;

  // one iteration of the bit-pair square root recurrence
  function automatic sq_t sq_step(sq_t s, int unsigned it);
    logic [SQW-1:0] bit_v;
    logic [SQW-1:0] trial;
    sq_t            o;
    bit_v = SQW'(1) << (62 - 2 * it);
    trial = s.res + bit_v;
    if (s.x >= trial) begin
      o.x   = s.x - trial;
      o.res = (s.res >> 1) + bit_v;
    end else begin
      o.x   = s.x;
      o.res = s.res >> 1;
    end
    return o;
  endfunction

endpackage

FILE: rtl/tun_isqrt.sv
// Pipelined integer square root, two result bits per stage.
`timescale 1ns / 1ps
module tun_isqrt (
  input  logic                    clk,
  input  logic                    en,
  input  logic [tun_pkg::SQW-1:0] x_in,
  output logic [tun_pkg::LW-1:0]  root
);

  tun_pkg::sq_t st_r [tun_pkg::SQ_STG];

  for (genvar s = 0; s < tun_pkg::SQ_STG; s++) begin : g_stg
    tun_pkg::sq_t st_in;
    tun_pkg::sq_t st_nxt;
    if (s == 0) begin : g_head
      assign st_in = '{x: x_in, res: '0};
    end else begin : g_body
      assign st_in = st_r[s-1];
    end
    always_comb begin
      tun_pkg::sq_t a;
      a      = tun_pkg::sq_step(st_in, 2 * s);
      st_nxt = tun_pkg::sq_step(a, 2 * s + 1);
    end
    always_ff @(posedge clk) begin
      if (en) begin
        st_r[s] <= st_nxt;
      end
    end
  end

  assign root = st_r[tun_pkg::SQ_STG-1].res[tun_pkg::LW-1:0];

endmodule

FILE: rtl/tun_div.sv
// Pipelined restoring divider, two quotient bits per stage (one in the last stage when QW is odd).
`timescale 1ns / 1ps
module tun_div (
  input  logic                     clk,
  input  logic                     en,
  input  logic [tun_pkg::NUMW-1:0] num,
  input  logic [tun_pkg::DENW-1:0] den,
  output logic [tun_pkg::QW-1:0]   quo
);

  logic [tun_pkg::NUMW-1:0] rem_r [tun_pkg::DV_STG];
  logic [tun_pkg::DENW-1:0] den_r [tun_pkg::DV_STG];
  logic [tun_pkg::QW-1:0]   quo_r [tun_pkg::DV_STG];

  for (genvar s = 0; s < tun_pkg::DV_STG; s++) begin : g_stg
    logic [tun_pkg::NUMW-1:0] rem_in;
    logic [tun_pkg::QW-1:0]   quo_in;
    logic [tun_pkg::NUMW-1:0] rem_nxt;
    logic [tun_pkg::QW-1:0]   quo_nxt;
    logic [tun_pkg::DENW-1:0] den_cur;
    if (s == 0) begin : g_head
      assign rem_in  = num;
      assign quo_in  = '0;
      assign den_cur = den;
    end else begin : g_body
      assign rem_in  = rem_r[s-1];
      assign quo_in  = quo_r[s-1];
      assign den_cur = den_r[s-1];
    end
    always_comb begin
      logic [tun_pkg::NUMW-1:0] sub;
      rem_nxt = rem_in;
      quo_nxt = quo_in;
      sub     = '0;
      for (int u = 0; u < 2; u++) begin
        if (2 * s + u < tun_pkg::QW) begin
          sub = tun_pkg::NUMW'(den_cur) << (tun_pkg::QW - 1 - (2 * s + u));
          if (rem_nxt >= sub) begin
            rem_nxt = rem_nxt - sub;
            quo_nxt[tun_pkg::QW - 1 - (2 * s + u)] = 1'b1;
          end
        end
      end
    end
    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[s] <= rem_nxt;
        quo_r[s] <= quo_nxt;
        den_r[s] <= den_cur;
      end
    end
  end

  assign quo = quo_r[tun_pkg::DV_STG-1];

endmodule

FILE: rtl/triangle_unit_normal_unit.sv
// Top level: triangle face normal, cross product scaled to unit length.
// Stages from input beat to output register: input capture, edges, products, cross, magnitude,
//   prescale search, shift, squares, sum, 16 isqrt stages, scaling, 8 divider stages.
// Throughput: one triangle per cycle; a stalled output freezes the whole pipe.
// Reset: synchronous active-low rst_n clears the valid bits; data registers are not reset.
`timescale 1ns / 1ps
module triangle_unit_normal_unit (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_stall,
  input  tun_pkg::in_t  in_data,
  output logic          out_valid,
  input  logic          out_stall,
  output tun_pkg::out_t out_data
);

  localparam int EW = tun_pkg::EW;
  localparam int PW = tun_pkg::PW;
  localparam int NW = tun_pkg::NW;
  localparam int MW = tun_pkg::MW;

  logic adv;
  logic [tun_pkg::LAT-1:0] vld_r;
  logic out_vld_r;
  tun_pkg::out_t out_r;

  assign adv      = !(out_vld_r && out_stall);
  assign in_stall = !adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r     <= '0;
      out_vld_r <= 1'b0;
    end else if (adv) begin
      vld_r     <= {vld_r[tun_pkg::LAT-2:0], in_valid};
      out_vld_r <= vld_r[tun_pkg::LAT-1];
    end
  end

  // stage 0: input capture
  tun_pkg::in_t in_r;
  always_ff @(posedge clk) begin
    if (adv) begin
      in_r <= in_data;
    end
  end

  // stage 1: edges
  logic signed [EW-1:0] e1_r [3];
  logic signed [EW-1:0] e2_r [3];
  always_ff @(posedge clk) begin
    if (adv) begin
      e1_r[0] <= EW'(in_r.first_x)  - EW'(in_r.apex_x);
      e1_r[1] <= EW'(in_r.first_y)  - EW'(in_r.apex_y);
      e1_r[2] <= EW'(in_r.first_z)  - EW'(in_r.apex_z);
      e2_r[0] <= EW'(in_r.second_x) - EW'(in_r.apex_x);
      e2_r[1] <= EW'(in_r.second_y) - EW'(in_r.apex_y);
      e2_r[2] <= EW'(in_r.second_z) - EW'(in_r.apex_z);
    end
  end

  // stage 2: products
  logic signed [PW-1:0] p_r [6];
  always_ff @(posedge clk) begin
    if (adv) begin
      p_r[0] <= e1_r[1] * e2_r[2];
      p_r[1] <= e1_r[2] * e2_r[1];
      p_r[2] <= e1_r[2] * e2_r[0];
      p_r[3] <= e1_r[0] * e2_r[2];
      p_r[4] <= e1_r[0] * e2_r[1];
      p_r[5] <= e1_r[1] * e2_r[0];
    end
  end

  // stage 3: cross product
  logic signed [NW-1:0] n_r [3];
  always_ff @(posedge clk) begin
    if (adv) begin
      for (int i = 0; i < 3; i++) begin
        n_r[i] <= NW'(p_r[2*i]) - NW'(p_r[2*i+1]);
      end
    end
  end

  // stage 4: magnitudes, signs, degenerate flag
  logic [NW-1:0] mag4_r [3];
  logic [2:0]    neg4_r;
  logic          deg4_r;
  always_ff @(posedge clk) begin
    if (adv) begin
      for (int i = 0; i < 3; i++) begin
        mag4_r[i] <= n_r[i][NW-1] ? NW'(-n_r[i]) : NW'(n_r[i]);
        neg4_r[i] <= n_r[i][NW-1];
      end
      deg4_r <= (n_r[0] == '0) && (n_r[1] == '0) && (n_r[2] == '0);
    end
  end

  // stage 5: prescale shift; the top bit of the OR is the top bit of the max
  logic [NW-1:0]          orv;
  logic [tun_pkg::KW-1:0] k_nxt;
  logic [tun_pkg::KW-1:0] k5_r;
  logic [NW-1:0]          mag5_r [3];
  logic [2:0]             neg5_r;
  logic                   deg5_r;
  always_comb begin
    orv   = mag4_r[0] | mag4_r[1] | mag4_r[2];
    k_nxt = '0;
    for (int j = 0; j < NW - MW; j++) begin
      if (orv[MW+j]) begin
        k_nxt = tun_pkg::KW'(j + 1);
      end
    end
  end
  always_ff @(posedge clk) begin
    if (adv) begin
      k5_r   <= k_nxt;
      mag5_r <= mag4_r;
      neg5_r <= neg4_r;
      deg5_r <= deg4_r;
    end
  end

  // stage 6: truncating shift
  logic [MW-1:0] m6_r [3];
  logic [2:0]    neg6_r;
  logic          deg6_r;
  always_ff @(posedge clk) begin
    if (adv) begin
      for (int i = 0; i < 3; i++) begin
        m6_r[i] <= MW'(mag5_r[i] >> k5_r);
      end
      neg6_r <= neg5_r;
      deg6_r <= deg5_r;
    end
  end

  // stage 7: squares
  logic [2*MW-1:0] sq7_r [3];
  logic [MW-1:0]   m7_r [3];
  logic [2:0]      neg7_r;
  logic            deg7_r;
  always_ff @(posedge clk) begin
    if (adv) begin
      for (int i = 0; i < 3; i++) begin
        sq7_r[i] <= m6_r[i] * m6_r[i];
      end
      m7_r   <= m6_r;
      neg7_r <= neg6_r;
      deg7_r <= deg6_r;
    end
  end

  // stage 8: sum of squares times 4096
  logic [tun_pkg::SQW-1:0] x8_r;
  logic [MW-1:0]           m8_r [3];
  logic [2:0]              neg8_r;
  logic                    deg8_r;
  always_ff @(posedge clk) begin
    if (adv) begin
      x8_r   <= (tun_pkg::SQW'(sq7_r[0]) + tun_pkg::SQW'(sq7_r[1])
                 + tun_pkg::SQW'(sq7_r[2])) << 12;
      m8_r   <= m7_r;
      neg8_r <= neg7_r;
      deg8_r <= deg7_r;
    end
  end

  // isqrt stages with sideband riding alongside
  logic [tun_pkg::LW-1:0] len;
  tun_isqrt u_isqrt (
    .clk  (clk),
    .en   (adv),
    .x_in (x8_r),
    .root (len)
  );

  logic [MW-1:0] sm_r   [tun_pkg::SQ_STG][3];
  logic [2:0]    sneg_r [tun_pkg::SQ_STG];
  logic          sdeg_r [tun_pkg::SQ_STG];
  always_ff @(posedge clk) begin
    if (adv) begin
      sm_r[0]   <= m8_r;
      sneg_r[0] <= neg8_r;
      sdeg_r[0] <= deg8_r;
      for (int s = 1; s < tun_pkg::SQ_STG; s++) begin
        sm_r[s]   <= sm_r[s-1];
        sneg_r[s] <= sneg_r[s-1];
        sdeg_r[s] <= sdeg_r[s-1];
      end
    end
  end

  // numerator m*2^21 + L, denominator 2L
  logic [tun_pkg::NUMW-1:0] num_r [3];
  logic [tun_pkg::DENW-1:0] den_r;
  always_ff @(posedge clk) begin
    if (adv) begin
      for (int i = 0; i < 3; i++) begin
        num_r[i] <= (tun_pkg::NUMW'(sm_r[tun_pkg::SQ_STG-1][i]) << 21)
                    + tun_pkg::NUMW'(len);
      end
      den_r <= {len, 1'b0};
    end
  end

  logic [2:0] dneg_r [tun_pkg::DV_STG + 1];
  logic       ddeg_r [tun_pkg::DV_STG + 1];
  always_ff @(posedge clk) begin
    if (adv) begin
      dneg_r[0] <= sneg_r[tun_pkg::SQ_STG-1];
      ddeg_r[0] <= sdeg_r[tun_pkg::SQ_STG-1];
      for (int s = 1; s <= tun_pkg::DV_STG; s++) begin
        dneg_r[s] <= dneg_r[s-1];
        ddeg_r[s] <= ddeg_r[s-1];
      end
    end
  end

  logic [tun_pkg::QW-1:0] q [3];
  for (genvar i = 0; i < 3; i++) begin : g_div
    tun_div u_div (
      .clk (clk),
      .en  (adv),
      .num (num_r[i]),
      .den (den_r),
      .quo (q[i])
    );
  end

  // output: clamp, sign, degenerate override
  logic signed [tun_pkg::OW-1:0] r [3];
  tun_pkg::out_t out_nxt;
  always_comb begin
    logic [tun_pkg::QW-1:0] qc;
    for (int i = 0; i < 3; i++) begin
      qc = (q[i] > tun_pkg::QW'(tun_pkg::NORM_ONE)) ? tun_pkg::QW'(tun_pkg::NORM_ONE) : q[i];
      if (ddeg_r[tun_pkg::DV_STG]) begin
        r[i] = '0;
      end else if (dneg_r[tun_pkg::DV_STG][i]) begin
        r[i] = -tun_pkg::OW'(qc);
      end else begin
        r[i] = tun_pkg::OW'(qc);
      end
    end
    out_nxt.normal_x   = r[0];
    out_nxt.normal_y   = r[1];
    out_nxt.normal_z   = r[2];
    out_nxt.degenerate = ddeg_r[tun_pkg::DV_STG];
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_r <= out_nxt;
    end
  end

  assign out_valid = out_vld_r;
  assign out_data  = out_r;

`ifndef SYNTHESIS
  a_stall_link: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall == (out_vld_r && out_stall))
    else $error("input stall does not follow output backpressure");

  a_freeze: assert property (@(posedge clk) disable iff (!rst_n)
    !adv |=> $stable(vld_r))
    else $error("pipeline valid bits moved during stall");

  a_degen_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.degenerate) |->
      (out_data.normal_x == 0 && out_data.normal_y == 0 && out_data.normal_z == 0))
    else $error("degenerate triangle with nonzero normal");

  a_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |->
      (out_data.normal_x <= 16384 && out_data.normal_x >= -16384 &&
       out_data.normal_y <= 16384 && out_data.normal_y >= -16384 &&
       out_data.normal_z <= 16384 && out_data.normal_z >= -16384))
    else $error("normal component out of range");
`endif

endmodule
